[design/qpt_pkg.sv]
// ----------------------------------------------------------------------------
// qpt_pkg: shared types, constants and helpers
// Fixed-point types, register indexes and multiply helpers for the
// quaternion point transform pipeline.
// ----------------------------------------------------------------------------
package qpt_pkg;

    // Pipeline depth from input transfer to result strobe.
    localparam int PIPE_DEPTH = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_TRANS_X = 3'd4,
        REG_TRANS_Y = 3'd5,
        REG_TRANS_Z = 3'd6,
        REG_SCALE   = 3'd7
    } t_cfg_idx;

    typedef logic signed [15:0] t_s16;   // Q1.14 quaternion / Q3.12 scale
    typedef logic signed [23:0] t_s24;   // coordinate, 8 fractional bits
    typedef logic signed [27:0] t_s28;   // scaled coordinate
    typedef logic signed [33:0] t_s34;   // rotated and rounded coordinate
    typedef logic signed [34:0] t_s35;   // translated sum before clamp
    typedef logic signed [37:0] t_p38;   // 16 x 22 partial product
    typedef logic signed [39:0] t_p40;   // 24 x 16 scale product
    typedef logic signed [43:0] t_p44;   // cross product term
    typedef logic signed [61:0] t_acc;   // 36 fractional bit accumulator

    // Control that travels with each item.
    typedef struct packed {
        logic valid;
        logic is_dir;
    } t_ctl;

    typedef struct packed {
        t_s16 w;
        t_s16 x;
        t_s16 y;
        t_s16 z;
    } t_quat;

    localparam t_quat QUAT_RESET  = '{w: 16'sd16384, x: '0, y: '0, z: '0};
    localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 48'h1000_1000_1000;

    localparam t_p40 ROUND12   = 40'sd2048;
    localparam t_acc ROUND28   = t_acc'(64'sd134217728);
    localparam t_s35 OUT_MAX35 = 35'sd8388607;
    localparam t_s35 OUT_MIN35 = -35'sd8388608;
    localparam t_s24 OUT_MAX   = 24'sd8388607;
    localparam t_s24 OUT_MIN   = -24'sd8388608;

    function automatic t_p40 mul_24x16(input t_s24 a, input t_s16 b);
        return t_p40'(a) * t_p40'(b);
    endfunction

    function automatic t_p44 mul_16x28(input t_s16 a, input t_s28 b);
        return t_p44'(a) * t_p44'(b);
    endfunction

    // Signed factor times signed upper half of a split operand.
    function automatic t_p38 mul_16x22s(input t_s16 a, input logic signed [21:0] b);
        return t_p38'(a) * t_p38'(b);
    endfunction

    // Signed factor times unsigned lower half of a split operand.
    function automatic t_p38 mul_16x22u(input t_s16 a, input logic [21:0] b);
        return t_p38'(a) * t_p38'(b);
    endfunction

endpackage

[design/quaternion_point_transform_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_point_transform_unit: scale, rotate and translate 3D coordinates
// Fully pipelined transform of one coordinate per clock while busy is low.
// ----------------------------------------------------------------------------
// Usage: one coordinate transfer is taken on every clock edge where start is
// high and busy is low; busy is high during reset and in the first cycle after
// it. Each transfer produces exactly one result, shown on the o_out_* ports
// with o_valid high for a single cycle. The pipeline never stalls and the
// receiver cannot hold a result off, so a result must be captured in its
// strobe cycle. Throughput is one coordinate per clock while busy is low;
// the pipeline has eight register stages: two for the per-axis scale, five
// for the quaternion rotation (cross product terms, their difference, 22-bit
// partial products of the second cross product and of w*c, merge, round) and
// one for translation and saturation.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata and take effect at once; write them only while no transfer is
// in flight, since items in the pipeline read them live.
// ----------------------------------------------------------------------------
module quaternion_point_transform_unit
    import qpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [23:0]           i_in_x,
    input  logic [23:0]           i_in_y,
    input  logic [23:0]           i_in_z,
    // result channel
    output logic                  o_valid,
    output logic [23:0]           o_out_x,
    output logic [23:0]           o_out_y,
    output logic [23:0]           o_out_z,
    output logic                  o_saturated,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration registers
    t_quat                 r_quat;
    t_s24                  r_trans [3];
    logic [CFG_DATA_W-1:0] r_scale;
    logic                  r_ready;

    t_ctl in_ctl;
    t_s24 in_vec [3];
    t_ctl scl_ctl, rot_ctl;
    t_s28 scl_s [3];
    t_s34 rot_r [3];
    t_s24 out_vec [3];

    // Keep busy high through reset and the first cycle after it, then accept every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end
    assign busy = !r_ready;

    // Register writes; the index space is fully decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat  <= QUAT_RESET;
            r_scale <= SCALE_RESET;
            for (int i = 0; i < 3; i++) begin
                r_trans[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_ROT_W:   r_quat.w   <= i_cfg_wdata[15:0];
                REG_ROT_X:   r_quat.x   <= i_cfg_wdata[15:0];
                REG_ROT_Y:   r_quat.y   <= i_cfg_wdata[15:0];
                REG_ROT_Z:   r_quat.z   <= i_cfg_wdata[15:0];
                REG_TRANS_X: r_trans[0] <= i_cfg_wdata[23:0];
                REG_TRANS_Y: r_trans[1] <= i_cfg_wdata[23:0];
                REG_TRANS_Z: r_trans[2] <= i_cfg_wdata[23:0];
                REG_SCALE:   r_scale    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A transfer enters stage one with its valid bit; idle cycles carry a bubble.
    assign in_ctl.valid  = start && !busy;
    assign in_ctl.is_dir = i_action;
    assign in_vec[0]     = i_in_x;
    assign in_vec[1]     = i_in_y;
    assign in_vec[2]     = i_in_z;

    qpt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_in    (in_vec),
        .i_scale (r_scale),
        .o_ctl   (scl_ctl),
        .o_s     (scl_s)
    );

    qpt_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scl_ctl),
        .i_s     (scl_s),
        .i_quat  (r_quat),
        .o_ctl   (rot_ctl),
        .o_r     (rot_r)
    );

    qpt_translate u_translate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (rot_ctl),
        .i_r         (rot_r),
        .i_trans     (r_trans),
        .o_valid     (o_valid),
        .o_out       (out_vec),
        .o_saturated (o_saturated)
    );

    assign o_out_x = out_vec[0];
    assign o_out_y = out_vec[1];
    assign o_out_z = out_vec[2];

    // Every accepted transfer leads to a result strobe on o_valid.
    a_latency_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_DEPTH o_valid)
        else $error("transfer lost in pipeline");

    // No result appears without a matching earlier transfer.
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without a transfer");

    // A clamp flag means at least one component sits on a rail.
    a_sat_rail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_x == OUT_MAX || o_out_x == OUT_MIN ||
             o_out_y == OUT_MAX || o_out_y == OUT_MIN ||
             o_out_z == OUT_MAX || o_out_z == OUT_MIN))
        else $error("saturation flag without clamped component");

endmodule

[design/qpt_scale.sv]
// ----------------------------------------------------------------------------
// qpt_scale: per-axis scaling
// Two stages: multiply each coordinate by its Q3.12 factor, then round
// to 8 fractional bits with halves toward plus infinity.
// ----------------------------------------------------------------------------
module qpt_scale
    import qpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    input  t_s24                  i_in [3],
    input  logic [CFG_DATA_W-1:0] i_scale,
    output t_ctl                  o_ctl,
    output t_s28                  o_s [3]
);

    t_ctl r_ctl1, r_ctl2;
    t_p40 r_p [3];
    t_s28 r_s [3];
    t_s16 scale [3];

    assign scale[0] = i_scale[15:0];
    assign scale[1] = i_scale[31:16];
    assign scale[2] = i_scale[47:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p[i] <= mul_24x16(i_in[i], scale[i]);
            r_s[i] <= t_s28'((r_p[i] + ROUND12) >>> 12);
        end
    end

    assign o_ctl = r_ctl2;
    assign o_s   = r_s;

endmodule

[design/qpt_rotate.sv]
// ----------------------------------------------------------------------------
// qpt_rotate: quaternion rotation
// Five stages computing v + 2w(u x v) + 2u x (u x v), rounded once to
// 8 fractional bits. Wide products are split into 22-bit halves.
// ----------------------------------------------------------------------------
module qpt_rotate
    import qpt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    input  t_s28  i_s [3],
    input  t_quat i_quat,
    output t_ctl  o_ctl,
    output t_s34  o_r [3]
);

    t_s16 u [3];
    t_ctl r_ctl [5];

    // stage 3: first cross product terms
    t_p44 r_pa [3];
    t_p44 r_pb [3];
    t_s28 r_s3 [3];
    // stage 4: c = u x s
    t_p44 r_c [3];
    t_s28 r_s4 [3];
    // stage 5: split partial products of u x c and w*c
    t_p38 r_qah [3];
    t_p38 r_qal [3];
    t_p38 r_qbh [3];
    t_p38 r_qbl [3];
    t_p38 r_wh [3];
    t_p38 r_wl [3];
    t_s28 r_s5 [3];
    // stage 6: d = u x c and w*c at full width
    t_acc r_d [3];
    t_acc r_wc [3];
    t_s28 r_s6 [3];
    // stage 7: rounded result
    t_s34 r_r [3];

    logic signed [21:0] c_hi [3];
    logic        [21:0] c_lo [3];

    assign u[0] = i_quat.x;
    assign u[1] = i_quat.y;
    assign u[2] = i_quat.z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_hi[i] = r_c[i][43:22];
            c_lo[i] = r_c[i][21:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < 5; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa[0] <= mul_16x28(u[1], i_s[2]);
        r_pb[0] <= mul_16x28(u[2], i_s[1]);
        r_pa[1] <= mul_16x28(u[2], i_s[0]);
        r_pb[1] <= mul_16x28(u[0], i_s[2]);
        r_pa[2] <= mul_16x28(u[0], i_s[1]);
        r_pb[2] <= mul_16x28(u[1], i_s[0]);

        r_qah[0] <= mul_16x22s(u[1], c_hi[2]);
        r_qal[0] <= mul_16x22u(u[1], c_lo[2]);
        r_qbh[0] <= mul_16x22s(u[2], c_hi[1]);
        r_qbl[0] <= mul_16x22u(u[2], c_lo[1]);
        r_qah[1] <= mul_16x22s(u[2], c_hi[0]);
        r_qal[1] <= mul_16x22u(u[2], c_lo[0]);
        r_qbh[1] <= mul_16x22s(u[0], c_hi[2]);
        r_qbl[1] <= mul_16x22u(u[0], c_lo[2]);
        r_qah[2] <= mul_16x22s(u[0], c_hi[1]);
        r_qal[2] <= mul_16x22u(u[0], c_lo[1]);
        r_qbh[2] <= mul_16x22s(u[1], c_hi[0]);
        r_qbl[2] <= mul_16x22u(u[1], c_lo[0]);

        for (int i = 0; i < 3; i++) begin
            r_s3[i] <= i_s[i];
            r_c[i]  <= r_pa[i] - r_pb[i];
            r_s4[i] <= r_s3[i];
            r_wh[i] <= mul_16x22s(i_quat.w, c_hi[i]);
            r_wl[i] <= mul_16x22u(i_quat.w, c_lo[i]);
            r_s5[i] <= r_s4[i];
            r_d[i]  <= ((t_acc'(r_qah[i]) - t_acc'(r_qbh[i])) <<< 22)
                     + (t_acc'(r_qal[i]) - t_acc'(r_qbl[i]));
            r_wc[i] <= (t_acc'(r_wh[i]) <<< 22) + t_acc'(r_wl[i]);
            r_s6[i] <= r_s5[i];
            // low 28 bits of the shifted term are zero: the rounding bias folds in
            r_r[i]  <= t_s34'((((t_acc'(r_s6[i]) <<< 28) | ROUND28)
                              + (r_wc[i] <<< 1) + (r_d[i] <<< 1)) >>> 28);
        end
    end

    assign o_ctl = r_ctl[4];
    assign o_r   = r_r;

endmodule

[design/qpt_translate.sv]
// ----------------------------------------------------------------------------
// qpt_translate: translation and saturation
// Add the translation for points, clamp to 24 bits and register the result.
// ----------------------------------------------------------------------------
module qpt_translate
    import qpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    input  t_s34 i_r [3],
    input  t_s24 i_trans [3],
    output logic o_valid,
    output t_s24 o_out [3],
    output logic o_saturated
);

    t_s35 sum [3];
    t_s24 clamped [3];
    logic [2:0] clip;

    logic r_valid;
    t_s24 r_out [3];
    logic r_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = t_s35'(i_r[i]) + (i_ctl.is_dir ? t_s35'(0) : t_s35'(i_trans[i]));
            if (sum[i] > OUT_MAX35) begin
                clamped[i] = OUT_MAX;
                clip[i]    = 1'b1;
            end else if (sum[i] < OUT_MIN35) begin
                clamped[i] = OUT_MIN;
                clip[i]    = 1'b1;
            end else begin
                clamped[i] = t_s24'(sum[i]);
                clip[i]    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= clamped;
        r_sat <= |clip;
    end

    assign o_valid     = r_valid;
    assign o_out       = r_out;
    assign o_saturated = r_sat;

endmodule
